/* sv/jsu_pkg.sv */
package jsu_pkg;

	// Parse modes of the front end
	typedef enum logic [2:0] {
		M_PLAIN,
		M_ESC,
		M_HEX1,
		M_BSL,
		M_U,
		M_HEX2,
		M_UTF8
	} mode_t;

	// Result kinds
	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_ERR  = 2'd1;
	localparam logic [1:0] KIND_END  = 2'd2;

	// Error codes
	localparam logic [3:0] ERR_CUT_ESC   = 4'd0;
	localparam logic [3:0] ERR_BAD_ESC   = 4'd1;
	localparam logic [3:0] ERR_CUT_HEX   = 4'd2;
	localparam logic [3:0] ERR_NON_HEX   = 4'd3;
	localparam logic [3:0] ERR_NO_LOW_U  = 4'd4;
	localparam logic [3:0] ERR_NOT_LOW   = 4'd5;
	localparam logic [3:0] ERR_LONE_LOW  = 4'd6;
	localparam logic [3:0] ERR_CONTROL   = 4'd7;
	localparam logic [3:0] ERR_BARE      = 4'd8;
	localparam logic [3:0] ERR_BAD_UTF8  = 4'd9;
	localparam logic [3:0] ERR_CUT_UTF8  = 4'd10;

	// Request type
	localparam logic REQ_BYTE = 1'b0;
	localparam logic REQ_END  = 1'b1;

	// Results per transaction and queue sizing
	localparam int NSLOT      = 4;
	localparam int CNT_W      = $clog2(NSLOT + 1);
	localparam int IDX_W      = $clog2(NSLOT);
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] kind;
		logic [3:0] code;
	} result_t;

	// All results caused by one input transaction
	typedef struct packed {
		logic [CNT_W-1:0]          count;
		result_t [NSLOT-1:0]       slot;
	} bundle_t;

	typedef struct packed {
		logic    valid;
		bundle_t bnd;
	} push_t;

	typedef struct packed {
		logic    empty;
		logic    full;
		bundle_t head;
	} fifo_stat_t;

endpackage

/* sv/jsu_if.sv */
interface jsu_in_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] in_byte;

	modport source (output valid, output req_type, output in_byte, input ready);
	modport sink (input valid, input req_type, input in_byte, output ready);
endinterface

interface jsu_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [1:0] out_kind;
	logic [3:0] error_code;
	logic       last_of_run;

	modport source (output valid, output out_byte, output out_kind, output error_code,
		output last_of_run, input ready);
	modport sink (input valid, input out_byte, input out_kind, input error_code,
		input last_of_run, output ready);
endinterface

/* sv/json_string_unescape_utf8_check_top.sv */
// Each result is written into the bundle queue and then loaded into the output register.
// Throughput: one input byte per cycle while the queue is not full; the output side delivers one
// result per cycle while out_ch.ready is high, so a \u escape yields up to four result bytes.
// A four-entry queue of per-transaction result bundles decouples parser and output.
// Reset (arst_n low, asynchronous) returns the parser to plain text and empties the queue.
module json_string_unescape_utf8_check_top
	import jsu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	jsu_in_if.sink     in_ch,
	jsu_out_if.source  out_ch
);

	push_t      push;
	fifo_stat_t stat;
	logic       pop;

	jsu_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.full   (stat.full),
		.push   (push)
	);

	jsu_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.stat   (stat)
	);

	jsu_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.pop    (pop),
		.out_ch (out_ch)
	);

endmodule

/* sv/jsu_front.sv */
module jsu_front
	import jsu_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	jsu_in_if.sink       in_ch,
	input  logic         full,
	output push_t        push
);

	mode_t       mode_q, mode_d;
	logic [1:0]  hex_cnt_q, hex_cnt_d;
	logic [11:0] hex_val_q, hex_val_d;
	logic [9:0]  high_q, high_d;
	logic [1:0]  left_q, left_d;
	logic [7:0]  clo_q, clo_d;
	logic [7:0]  chi_q, chi_d;
	logic        failed_q, failed_d;

	logic        acc;
	logic [7:0]  c;
	logic        dig_ok;
	logic [3:0]  dig;
	logic [15:0] v;
	logic        v_high, v_low;
	logic [20:0] cp;
	logic        esc_ok;
	logic [7:0]  esc_val;
	bundle_t     bnd;

	function automatic result_t mk_data(input logic [7:0] b);
		result_t r;
		r.out_byte = b;
		r.kind = KIND_DATA;
		r.code = 4'd0;
		return r;
	endfunction

	function automatic result_t mk_err(input logic [3:0] e);
		result_t r;
		r.out_byte = 8'd0;
		r.kind = KIND_ERR;
		r.code = e;
		return r;
	endfunction

	function automatic result_t mk_end();
		result_t r;
		r.out_byte = 8'd0;
		r.kind = KIND_END;
		r.code = 4'd0;
		return r;
	endfunction

	assign in_ch.ready = !full;
	assign acc = in_ch.valid && in_ch.ready;
	assign c = in_ch.in_byte;

	// Hex digit decode
	always_comb begin
		dig_ok = 1'b1;
		dig = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			dig = 4'(c - 8'h30);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			dig = 4'(c - 8'h37);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			dig = 4'(c - 8'h57);
		end else begin
			dig_ok = 1'b0;
		end
	end

	assign v = {hex_val_q, dig};
	assign v_high = (v >= 16'hd800) && (v <= 16'hdbff);
	assign v_low = (v >= 16'hdc00) && (v <= 16'hdfff);

	// Code point: plain BMP value or surrogate pair
	assign cp = (mode_q == M_HEX1) ? {5'd0, v} : (21'h10000 + {1'b0, high_q, v[9:0]});

	// Simple escapes
	always_comb begin
		esc_ok = 1'b1;
		esc_val = c;
		case (c)
			8'h22, 8'h5c, 8'h2f: esc_val = c;
			8'h62: esc_val = 8'h08;
			8'h66: esc_val = 8'h0c;
			8'h6e: esc_val = 8'h0a;
			8'h72: esc_val = 8'h0d;
			8'h74: esc_val = 8'h09;
			default: esc_ok = 1'b0;
		endcase
	end

	// Next state
	always_comb begin
		mode_d = mode_q;
		hex_cnt_d = hex_cnt_q;
		hex_val_d = hex_val_q;
		high_d = high_q;
		left_d = left_q;
		clo_d = clo_q;
		chi_d = chi_q;
		failed_d = failed_q;
		if (in_ch.req_type == REQ_END) begin
			mode_d = M_PLAIN;
			hex_cnt_d = 2'd0;
			hex_val_d = 12'd0;
			high_d = 10'd0;
			left_d = 2'd0;
			clo_d = 8'h80;
			chi_d = 8'hbf;
			failed_d = 1'b0;
		end else if (!failed_q) begin
			case (mode_q)
				M_ESC: begin
					mode_d = M_PLAIN;
					if (c == 8'h75) begin
						mode_d = M_HEX1;
						hex_cnt_d = 2'd0;
						hex_val_d = 12'd0;
					end else if (!esc_ok) begin
						failed_d = 1'b1;
					end
				end
				M_HEX1, M_HEX2: begin
					if (!dig_ok) begin
						failed_d = 1'b1;
					end else begin
						hex_val_d = v[11:0];
						if (hex_cnt_q != 2'd3) begin
							hex_cnt_d = hex_cnt_q + 2'd1;
						end else begin
							hex_cnt_d = 2'd0;
							if (mode_q == M_HEX1) begin
								if (v_high) begin
									high_d = v[9:0];
									mode_d = M_BSL;
								end else if (v_low) begin
									failed_d = 1'b1;
								end else begin
									mode_d = M_PLAIN;
								end
							end else if (!v_low) begin
								failed_d = 1'b1;
							end else begin
								mode_d = M_PLAIN;
							end
						end
					end
				end
				M_BSL: begin
					if (c == 8'h5c) mode_d = M_U;
					else failed_d = 1'b1;
				end
				M_U: begin
					if (c == 8'h75) begin
						mode_d = M_HEX2;
						hex_cnt_d = 2'd0;
						hex_val_d = 12'd0;
					end else begin
						failed_d = 1'b1;
					end
				end
				M_UTF8: begin
					if (c < clo_q || c > chi_q) begin
						failed_d = 1'b1;
					end else begin
						clo_d = 8'h80;
						chi_d = 8'hbf;
						left_d = left_q - 2'd1;
						if (left_q == 2'd1) mode_d = M_PLAIN;
					end
				end
				default: begin
					// plain text, also any stray mode code
					mode_d = M_PLAIN;
					if (c == 8'h5c) begin
						mode_d = M_ESC;
					end else if (c <= 8'h1f || c == 8'h22) begin
						failed_d = 1'b1;
					end else if (c <= 8'h7f) begin
						mode_d = M_PLAIN;
					end else if (c >= 8'hc2 && c <= 8'hdf) begin
						mode_d = M_UTF8; left_d = 2'd1; clo_d = 8'h80; chi_d = 8'hbf;
					end else if (c == 8'he0) begin
						mode_d = M_UTF8; left_d = 2'd2; clo_d = 8'ha0; chi_d = 8'hbf;
					end else if (c == 8'hed) begin
						mode_d = M_UTF8; left_d = 2'd2; clo_d = 8'h80; chi_d = 8'h9f;
					end else if (c >= 8'he1 && c <= 8'hef) begin
						mode_d = M_UTF8; left_d = 2'd2; clo_d = 8'h80; chi_d = 8'hbf;
					end else if (c == 8'hf0) begin
						mode_d = M_UTF8; left_d = 2'd3; clo_d = 8'h90; chi_d = 8'hbf;
					end else if (c >= 8'hf1 && c <= 8'hf3) begin
						mode_d = M_UTF8; left_d = 2'd3; clo_d = 8'h80; chi_d = 8'hbf;
					end else if (c == 8'hf4) begin
						mode_d = M_UTF8; left_d = 2'd3; clo_d = 8'h80; chi_d = 8'h8f;
					end else begin
						failed_d = 1'b1;
					end
				end
			endcase
		end
	end

	// Results of this transaction
	always_comb begin
		bnd = '0;
		if (in_ch.req_type == REQ_END) begin
			bnd.count = CNT_W'(1);
			bnd.slot[0] = mk_end();
			if (!failed_q) begin
				case (mode_q)
					M_ESC: begin
						bnd.count = CNT_W'(2); bnd.slot[0] = mk_err(ERR_CUT_ESC);
						bnd.slot[1] = mk_end();
					end
					M_HEX1, M_HEX2: begin
						bnd.count = CNT_W'(2); bnd.slot[0] = mk_err(ERR_CUT_HEX);
						bnd.slot[1] = mk_end();
					end
					M_BSL, M_U: begin
						bnd.count = CNT_W'(2); bnd.slot[0] = mk_err(ERR_NO_LOW_U);
						bnd.slot[1] = mk_end();
					end
					M_UTF8: begin
						bnd.count = CNT_W'(2); bnd.slot[0] = mk_err(ERR_CUT_UTF8);
						bnd.slot[1] = mk_end();
					end
					default: bnd.count = CNT_W'(1);
				endcase
			end
		end else if (!failed_q) begin
			case (mode_q)
				M_ESC: begin
					if (c == 8'h75) begin
						bnd.count = '0;
					end else if (esc_ok) begin
						bnd.count = CNT_W'(1); bnd.slot[0] = mk_data(esc_val);
					end else begin
						bnd.count = CNT_W'(1); bnd.slot[0] = mk_err(ERR_BAD_ESC);
					end
				end
				M_HEX1, M_HEX2: begin
					if (!dig_ok) begin
						bnd.count = CNT_W'(1); bnd.slot[0] = mk_err(ERR_NON_HEX);
					end else if (hex_cnt_q != 2'd3) begin
						bnd.count = '0;
					end else if (mode_q == M_HEX1 && v_high) begin
						bnd.count = '0;
					end else if (mode_q == M_HEX1 && v_low) begin
						bnd.count = CNT_W'(1); bnd.slot[0] = mk_err(ERR_LONE_LOW);
					end else if (mode_q == M_HEX2 && !v_low) begin
						bnd.count = CNT_W'(1); bnd.slot[0] = mk_err(ERR_NOT_LOW);
					end else if (cp < 21'h80) begin
						bnd.count = CNT_W'(1);
						bnd.slot[0] = mk_data(cp[7:0]);
					end else if (cp <= 21'h7ff) begin
						bnd.count = CNT_W'(2);
						bnd.slot[0] = mk_data({3'b110, cp[10:6]});
						bnd.slot[1] = mk_data({2'b10, cp[5:0]});
					end else if (cp <= 21'hffff) begin
						bnd.count = CNT_W'(3);
						bnd.slot[0] = mk_data({4'b1110, cp[15:12]});
						bnd.slot[1] = mk_data({2'b10, cp[11:6]});
						bnd.slot[2] = mk_data({2'b10, cp[5:0]});
					end else begin
						bnd.count = CNT_W'(4);
						bnd.slot[0] = mk_data({5'b11110, cp[20:18]});
						bnd.slot[1] = mk_data({2'b10, cp[17:12]});
						bnd.slot[2] = mk_data({2'b10, cp[11:6]});
						bnd.slot[3] = mk_data({2'b10, cp[5:0]});
					end
				end
				M_BSL: begin
					if (c != 8'h5c) begin
						bnd.count = CNT_W'(1); bnd.slot[0] = mk_err(ERR_NO_LOW_U);
					end
				end
				M_U: begin
					if (c != 8'h75) begin
						bnd.count = CNT_W'(1); bnd.slot[0] = mk_err(ERR_NO_LOW_U);
					end
				end
				M_UTF8: begin
					bnd.count = CNT_W'(1);
					if (c < clo_q || c > chi_q) bnd.slot[0] = mk_err(ERR_BAD_UTF8);
					else bnd.slot[0] = mk_data(c);
				end
				default: begin
					bnd.count = CNT_W'(1);
					if (c == 8'h5c) bnd.count = '0;
					else if (c <= 8'h1f) bnd.slot[0] = mk_err(ERR_CONTROL);
					else if (c == 8'h22) bnd.slot[0] = mk_err(ERR_BARE);
					else if (c <= 8'h7f) bnd.slot[0] = mk_data(c);
					else if (c >= 8'hc2 && c <= 8'hf4) bnd.slot[0] = mk_data(c);
					else bnd.slot[0] = mk_err(ERR_BAD_UTF8);
				end
			endcase
		end
	end

	assign push.valid = acc && (bnd.count != '0);
	assign push.bnd = bnd;

	// Parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_PLAIN;
			hex_cnt_q <= 2'd0;
			hex_val_q <= 12'd0;
			high_q <= 10'd0;
			left_q <= 2'd0;
			clo_q <= 8'h80;
			chi_q <= 8'hbf;
			failed_q <= 1'b0;
		end else if (acc) begin
			mode_q <= mode_d;
			hex_cnt_q <= hex_cnt_d;
			hex_val_q <= hex_val_d;
			high_q <= high_d;
			left_q <= left_d;
			clo_q <= clo_d;
			chi_q <= chi_d;
			failed_q <= failed_d;
		end
	end

	// End marker always returns the parser to its idle state
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && in_ch.req_type == REQ_END) |=> (mode_q == M_PLAIN && !failed_q))
		else $error("parser not idle after end of string");

	// An error stops all further results until the end marker
	a_quiet_after_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(failed_q && in_ch.req_type == REQ_BYTE) |-> !push.valid)
		else $error("result produced after an error");

	// Inside a multibyte sequence, continuation bytes are always pending
	a_left_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == M_UTF8 && !failed_q) |-> (left_q != 2'd0))
		else $error("multibyte sequence with no bytes left");

endmodule

/* sv/jsu_fifo.sv */
module jsu_fifo
	import jsu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  push_t      push,
	input  logic       pop,
	output fifo_stat_t stat
);

	bundle_t            mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q;
	logic [FIFO_AW-1:0] rd_q;
	logic [FIFO_CW-1:0] cnt_q;
	logic               do_push;
	logic               do_pop;

	assign stat.empty = (cnt_q == '0);
	assign stat.full = (cnt_q == FIFO_CW'(FIFO_DEPTH));
	assign stat.head = mem_q[rd_q];
	assign do_push = push.valid && !stat.full;
	assign do_pop = pop && !stat.empty;

	// Bundle storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push.bnd;
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + FIFO_AW'(1);
			if (do_pop) rd_q <= rd_q + FIFO_AW'(1);
			if (do_push && !do_pop) cnt_q <= cnt_q + FIFO_CW'(1);
			else if (!do_push && do_pop) cnt_q <= cnt_q - FIFO_CW'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push.valid && stat.full))
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && stat.empty))
		else $error("pop from empty queue");

endmodule

/* sv/jsu_back.sv */
module jsu_back
	import jsu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  fifo_stat_t  stat,
	output logic        pop,
	jsu_out_if.source   out_ch
);

	logic [IDX_W-1:0] idx_q;
	logic             vld_q;
	result_t          res_q;
	logic             last_q;
	logic             load;
	logic             last_slot;
	result_t          cur;

	assign cur = stat.head.slot[idx_q];
	assign last_slot = ({1'b0, idx_q} == (stat.head.count - CNT_W'(1)));
	assign load = !stat.empty && (!vld_q || out_ch.ready);
	assign pop = load && last_slot;

	// Slot walk and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			vld_q <= 1'b0;
		end else begin
			if (load) begin
				vld_q <= 1'b1;
				idx_q <= last_slot ? '0 : idx_q + IDX_W'(1);
			end else if (out_ch.ready) begin
				vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= cur;
			last_q <= last_slot;
		end
	end

	assign out_ch.valid = vld_q;
	assign out_ch.out_byte = res_q.out_byte;
	assign out_ch.out_kind = res_q.kind;
	assign out_ch.error_code = res_q.code;
	assign out_ch.last_of_run = last_q;

	// The slot index never passes the head bundle's result count
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		!stat.empty |-> ({1'b0, idx_q} < stat.head.count))
		else $error("slot index beyond bundle");

	// Walk restarts at slot zero for every new bundle
	a_idx_restart: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (idx_q == '0))
		else $error("slot index not reset after pop");

endmodule

/* test/json_string_unescape_utf8_check_top_test.sv */
`timescale 1ns / 1ps

module json_string_unescape_utf8_check_top_test;
	import jsu_pkg::*;

	localparam int RANDOM_ITEMS = 410;
	localparam int CYCLE_LIMIT  = 100000;
	localparam int IDLE_PCT     = 9;
	localparam int CALM_FROM    = 150;
	localparam int CALM_TO      = 260;
	localparam int HOLD_AT      = 320;
	localparam int HOLD_CYCLES  = 48;
	localparam int DRAIN_CYCLES = 20;
	localparam logic [3:0] NO_CODE = 4'd0;

	// One input transaction: a body byte or the end marker
	typedef struct packed {
		logic       req;
		logic [7:0] data;
	} body_item_t;

	// One decoded result as seen on the output channel
	typedef struct packed {
		logic [7:0] b;
		logic [1:0] kind;
		logic [3:0] code;
		logic       last;
	} decoded_t;

	logic clk;
	logic arst_n;

	jsu_in_if  in_ch ();
	jsu_out_if out_ch ();

	json_string_unescape_utf8_check_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always #2 clk = ~clk;

	body_item_t body_q[$];
	logic [7:0] seg[$];
	decoded_t   step_out[$];
	decoded_t   expected_q[$];
	body_item_t next_item;

	int  cycles;
	int  accepted_n;
	int  fail_n;
	int  hold_left;
	bit  hold_done;
	bit  in_took;
	logic calm;

	// Decoder state of the predictor
	mode_t       p_mode;
	logic [1:0]  p_hex_n;
	logic [15:0] p_hex;
	logic [9:0]  p_high;
	logic [1:0]  p_left;
	logic [7:0]  p_lo;
	logic [7:0]  p_hi;
	logic        p_failed;

	task automatic log_failure(input string msg);
		$display("ERROR at cycle %0d: %s", cycles, msg);
		fail_n++;
	endtask

	task automatic clear_parser();
		p_mode   = M_PLAIN;
		p_hex_n  = '0;
		p_hex    = '0;
		p_high   = '0;
		p_left   = '0;
		p_lo     = 8'h80;
		p_hi     = 8'hbf;
		p_failed = 1'b0;
	endtask

	task automatic put_result(input logic [7:0] b, input logic [1:0] kind, input logic [3:0] code);
		decoded_t r;
		r.b    = b;
		r.kind = kind;
		r.code = code;
		r.last = 1'b0;
		step_out.insert(step_out.size(), r);
	endtask

	task automatic raise_parse_error(input logic [3:0] code);
		put_result(8'h00, KIND_ERR, code);
		p_failed = 1'b1;
	endtask

	function automatic int hex_val(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
		if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
		if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
		return -1;
	endfunction

	// Code point to UTF-8, one to four bytes
	task automatic emit_code_point(input logic [20:0] cp);
		if (cp < 21'h80) begin
			put_result(cp[7:0], KIND_DATA, NO_CODE);
		end else if (cp <= 21'h7ff) begin
			put_result({3'b110, cp[10:6]}, KIND_DATA, NO_CODE);
			put_result({2'b10, cp[5:0]}, KIND_DATA, NO_CODE);
		end else if (cp <= 21'hffff) begin
			put_result({4'b1110, cp[15:12]}, KIND_DATA, NO_CODE);
			put_result({2'b10, cp[11:6]}, KIND_DATA, NO_CODE);
			put_result({2'b10, cp[5:0]}, KIND_DATA, NO_CODE);
		end else begin
			put_result({5'b11110, cp[20:18]}, KIND_DATA, NO_CODE);
			put_result({2'b10, cp[17:12]}, KIND_DATA, NO_CODE);
			put_result({2'b10, cp[11:6]}, KIND_DATA, NO_CODE);
			put_result({2'b10, cp[5:0]}, KIND_DATA, NO_CODE);
		end
	endtask

	task automatic open_sequence(input logic [1:0] left, input logic [7:0] lo, input logic [7:0] hi);
		p_mode = M_UTF8;
		p_left = left;
		p_lo   = lo;
		p_hi   = hi;
	endtask

	// Unescaped byte outside any sequence
	task automatic plain_step(input logic [7:0] c);
		bit lead_ok;
		lead_ok = 1'b1;
		if (c == 8'h5c) begin
			p_mode = M_ESC;
		end else if (c <= 8'h1f) begin
			raise_parse_error(ERR_CONTROL);
		end else if (c == 8'h22) begin
			raise_parse_error(ERR_BARE);
		end else if (c <= 8'h7f) begin
			put_result(c, KIND_DATA, NO_CODE);
		end else begin
			if (c >= 8'hc2 && c <= 8'hdf) open_sequence(2'd1, 8'h80, 8'hbf);
			else if (c == 8'he0) open_sequence(2'd2, 8'ha0, 8'hbf);
			else if (c == 8'hed) open_sequence(2'd2, 8'h80, 8'h9f);
			else if (c >= 8'he1 && c <= 8'hef) open_sequence(2'd2, 8'h80, 8'hbf);
			else if (c == 8'hf0) open_sequence(2'd3, 8'h90, 8'hbf);
			else if (c >= 8'hf1 && c <= 8'hf3) open_sequence(2'd3, 8'h80, 8'hbf);
			else if (c == 8'hf4) open_sequence(2'd3, 8'h80, 8'h8f);
			else lead_ok = 1'b0;
			if (lead_ok) put_result(c, KIND_DATA, NO_CODE);
			else raise_parse_error(ERR_BAD_UTF8);
		end
	endtask

	// Byte right after a backslash
	task automatic escape_step(input logic [7:0] c);
		p_mode = M_PLAIN;
		case (c)
			8'h22, 8'h5c, 8'h2f: put_result(c, KIND_DATA, NO_CODE);
			8'h62: put_result(8'h08, KIND_DATA, NO_CODE);
			8'h66: put_result(8'h0c, KIND_DATA, NO_CODE);
			8'h6e: put_result(8'h0a, KIND_DATA, NO_CODE);
			8'h72: put_result(8'h0d, KIND_DATA, NO_CODE);
			8'h74: put_result(8'h09, KIND_DATA, NO_CODE);
			8'h75: begin
				p_mode  = M_HEX1;
				p_hex_n = '0;
				p_hex   = '0;
			end
			default: raise_parse_error(ERR_BAD_ESC);
		endcase
	endtask

	// Hex digit of a \u escape; the fourth digit completes the unit
	task automatic hex_step(input logic [7:0] c);
		int d;
		logic [15:0] v;
		d = hex_val(c);
		if (d < 0) begin
			raise_parse_error(ERR_NON_HEX);
		end else begin
			p_hex = {p_hex[11:0], d[3:0]};
			if (p_hex_n != 2'd3) begin
				p_hex_n++;
			end else begin
				p_hex_n = '0;
				v = p_hex;
				if (p_mode == M_HEX1) begin
					if (v >= 16'hd800 && v <= 16'hdbff) begin
						p_high = v[9:0];
						p_mode = M_BSL;
					end else if (v >= 16'hdc00 && v <= 16'hdfff) begin
						raise_parse_error(ERR_LONE_LOW);
					end else begin
						p_mode = M_PLAIN;
						emit_code_point({5'd0, v});
					end
				end else if (v < 16'hdc00 || v > 16'hdfff) begin
					raise_parse_error(ERR_NOT_LOW);
				end else begin
					p_mode = M_PLAIN;
					emit_code_point(21'h10000 + {1'b0, p_high, v[9:0]});
				end
			end
		end
	endtask

	task automatic cont_step(input logic [7:0] c);
		if (c < p_lo || c > p_hi) begin
			raise_parse_error(ERR_BAD_UTF8);
		end else begin
			put_result(c, KIND_DATA, NO_CODE);
			p_lo   = 8'h80;
			p_hi   = 8'hbf;
			p_left = p_left - 2'd1;
			if (p_left == 2'd0) p_mode = M_PLAIN;
		end
	endtask

	// Expected results of one accepted input transaction
	task automatic predict_transaction(input logic req, input logic [7:0] c);
		decoded_t r;
		step_out.delete();
		if (req == REQ_END) begin
			if (!p_failed) begin
				case (p_mode)
					M_ESC: raise_parse_error(ERR_CUT_ESC);
					M_HEX1, M_HEX2: raise_parse_error(ERR_CUT_HEX);
					M_BSL, M_U: raise_parse_error(ERR_NO_LOW_U);
					M_UTF8: raise_parse_error(ERR_CUT_UTF8);
					default: ;
				endcase
			end
			put_result(8'h00, KIND_END, NO_CODE);
			clear_parser();
		end else if (!p_failed) begin
			case (p_mode)
				M_ESC: escape_step(c);
				M_HEX1, M_HEX2: hex_step(c);
				M_BSL: begin
					if (c == 8'h5c) p_mode = M_U;
					else raise_parse_error(ERR_NO_LOW_U);
				end
				M_U: begin
					if (c == 8'h75) begin
						p_mode  = M_HEX2;
						p_hex_n = '0;
						p_hex   = '0;
					end else begin
						raise_parse_error(ERR_NO_LOW_U);
					end
				end
				M_UTF8: cont_step(c);
				default: plain_step(c);
			endcase
		end
		for (int i = 0; i < step_out.size(); i++) begin
			r = step_out[i];
			r.last = (i == step_out.size() - 1);
			expected_q.insert(expected_q.size(), r);
		end
	endtask

	task automatic check_result();
		decoded_t want;
		if (expected_q.size() == 0) begin
			log_failure($sformatf("unexpected result byte %h kind %0d code %0d",
				out_ch.out_byte, out_ch.out_kind, out_ch.error_code));
		end else begin
			want = expected_q.pop_front();
			if (out_ch.out_byte !== want.b)
				log_failure($sformatf("out_byte %h, expected %h", out_ch.out_byte, want.b));
			if (out_ch.out_kind !== want.kind)
				log_failure($sformatf("out_kind %0d, expected %0d", out_ch.out_kind, want.kind));
			if (out_ch.error_code !== want.code)
				log_failure($sformatf("error_code %0d, expected %0d", out_ch.error_code,
					want.code));
			if (out_ch.last_of_run !== want.last)
				log_failure($sformatf("last_of_run %b, expected %b", out_ch.last_of_run,
					want.last));
		end
	endtask

	// Stimulus construction
	task automatic queue_byte(input logic [7:0] b);
		body_item_t it;
		it.req  = REQ_BYTE;
		it.data = b;
		body_q.insert(body_q.size(), it);
	endtask

	task automatic queue_end();
		body_item_t it;
		it.req  = REQ_END;
		it.data = 8'($urandom_range(0, 255));
		body_q.insert(body_q.size(), it);
	endtask

	task automatic queue_text(input string s);
		for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
	endtask

	// Append one byte to the segment under construction
	task automatic seg_add(input logic [7:0] b);
		seg.insert(seg.size(), b);
	endtask

	function automatic logic [7:0] hex_ascii(input logic [3:0] n);
		if (n < 4'd10) return 8'h30 + n;
		return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + n - 8'd10;
	endfunction

	task automatic seg_u_escape(input logic [15:0] v);
		seg_add(8'h5c);
		seg_add(8'h75);
		seg_add(hex_ascii(v[15:12]));
		seg_add(hex_ascii(v[11:8]));
		seg_add(hex_ascii(v[7:4]));
		seg_add(hex_ascii(v[3:0]));
	endtask

	// Well-formed multibyte UTF-8 sequence
	task automatic seg_utf8();
		logic [7:0] lead;
		logic [7:0] lo;
		logic [7:0] hi;
		int n;
		int r;
		n  = $urandom_range(2, 4);
		r  = $urandom_range(0, 3);
		lo = 8'h80;
		hi = 8'hbf;
		if (n == 2) begin
			lead = 8'($urandom_range(8'hc2, 8'hdf));
		end else if (n == 3) begin
			if (r == 0) begin
				lead = 8'he0;
				lo   = 8'ha0;
			end else if (r == 1) begin
				lead = 8'hed;
				hi   = 8'h9f;
			end else begin
				lead = 8'($urandom_range(8'he1, 8'hef));
				if (lead == 8'hed) lead = 8'hee;
			end
		end else begin
			if (r == 0) begin
				lead = 8'hf0;
				lo   = 8'h90;
			end else if (r == 1) begin
				lead = 8'hf4;
				hi   = 8'h8f;
			end else begin
				lead = 8'($urandom_range(8'hf1, 8'hf3));
			end
		end
		seg_add(lead);
		seg_add(8'($urandom_range(lo, hi)));
		for (int i = 2; i < n; i++) seg_add(8'($urandom_range(8'h80, 8'hbf)));
	endtask

	// Mostly malformed input of several flavors
	task automatic seg_noise();
		int r;
		r = $urandom_range(0, 5);
		case (r)
			0: repeat ($urandom_range(1, 3)) seg_add(8'($urandom_range(0, 255)));
			1: begin
				seg_add(8'h5c);
				seg_add(8'($urandom_range(0, 255)));
			end
			2: begin
				seg_add(8'h5c);
				seg_add(8'h75);
				repeat (4) seg_add(($urandom_range(0, 4) == 0) ?
					8'($urandom_range(0, 255)) : hex_ascii(4'($urandom_range(0, 15))));
			end
			3: begin
				seg_u_escape(16'hd800 + 16'($urandom_range(0, 16'h3ff)));
				case ($urandom_range(0, 2))
					0: seg_add(8'($urandom_range(0, 255)));
					1: begin
						seg_add(8'h5c);
						seg_add(8'($urandom_range(0, 255)));
					end
					default: seg_u_escape(16'($urandom_range(0, 16'hffff)));
				endcase
			end
			4: seg_u_escape(16'hdc00 + 16'($urandom_range(0, 16'h3ff)));
			default: begin
				seg_add(8'($urandom_range(8'hc2, 8'hf4)));
				seg_add(8'($urandom_range(0, 255)));
			end
		endcase
	endtask

	// One random string body: mostly well-formed pieces, sometimes cut or broken
	task automatic queue_random_string();
		int nseg;
		int cut_at;
		int pick;
		int keep;
		logic [7:0] b;
		logic [15:0] v;
		nseg   = $urandom_range(1, 6);
		cut_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, nseg - 1) : -1;
		for (int s = 0; s < nseg; s++) begin
			seg.delete();
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				repeat ($urandom_range(1, 4)) begin
					do b = 8'($urandom_range(8'h20, 8'h7f)); while (b == 8'h22 || b == 8'h5c);
					seg_add(b);
				end
			end else if (pick < 45) begin
				seg_add(8'h5c);
				case ($urandom_range(0, 7))
					0: seg_add(8'h22);
					1: seg_add(8'h5c);
					2: seg_add(8'h2f);
					3: seg_add(8'h62);
					4: seg_add(8'h66);
					5: seg_add(8'h6e);
					6: seg_add(8'h72);
					default: seg_add(8'h74);
				endcase
			end else if (pick < 60) begin
				case ($urandom_range(0, 2))
					0: v = 16'($urandom_range(0, 16'h7f));
					1: v = 16'($urandom_range(16'h80, 16'h7ff));
					default: v = 16'($urandom_range(16'h800, 16'hffff));
				endcase
				if (v >= 16'hd800 && v <= 16'hdfff) v = v ^ 16'h4000;
				seg_u_escape(v);
			end else if (pick < 70) begin
				seg_u_escape(16'hd800 + 16'($urandom_range(0, 16'h3ff)));
				seg_u_escape(16'hdc00 + 16'($urandom_range(0, 16'h3ff)));
			end else if (pick < 92) begin
				seg_utf8();
			end else begin
				seg_noise();
			end
			if (s == cut_at && seg.size() > 1) begin
				keep = $urandom_range(1, seg.size() - 1);
				for (int i = 0; i < keep; i++) queue_byte(seg[i]);
				break;
			end
			foreach (seg[i]) queue_byte(seg[i]);
			if (pick >= 92) begin
				// a few trailing bytes that a failed string must swallow
				repeat ($urandom_range(0, 2)) queue_byte(8'($urandom_range(0, 255)));
				break;
			end
		end
		queue_end();
	endtask

	// Input driver: changes at the falling edge, holds until the transaction is taken
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_ch.valid || in_took) begin
				if (body_q.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
					next_item = body_q.pop_front();
					in_ch.valid    <= 1'b1;
					in_ch.req_type <= next_item.req;
					in_ch.in_byte  <= next_item.data;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Output ready: random stalls, plus one long hold-off to back the block up
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_ch.ready <= 1'b0;
		end else if (!hold_done && accepted_n >= HOLD_AT) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	assign calm = (accepted_n >= CALM_FROM) && (accepted_n < CALM_TO);

	// Monitor: predict on input transactions, then check output transactions
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("*** FAILED ***");
			$finish;
		end else if (arst_n) begin
			in_took <= in_ch.valid && in_ch.ready;
			if (in_ch.valid && in_ch.ready) begin
				predict_transaction(in_ch.req_type, in_ch.in_byte);
				accepted_n++;
			end
			if (out_ch.valid && out_ch.ready) check_result();
		end
	end

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		in_ch.valid    = 1'b0;
		in_ch.req_type = REQ_BYTE;
		in_ch.in_byte  = 8'h00;
		out_ch.ready   = 1'b0;
		cycles         = 0;
		accepted_n     = 0;
		fail_n         = 0;
		hold_left      = 0;
		hold_done      = 1'b0;
		in_took        = 1'b0;
		clear_parser();

		// space, DEL, \u0000 and a surrogate pair with mixed-case digits
		queue_byte(8'h20);
		queue_byte(8'h7f);
		queue_text("\\u0000\\ud83D\\uDe00");
		queue_end();
		// backslash inside a UTF-8 sequence; the next byte is swallowed
		queue_byte(8'he0);
		queue_byte(8'h5c);
		queue_byte(8'h41);
		queue_end();
		// bare quote, control character, cut escape, cut UTF-8
		queue_byte(8'h22);
		queue_end();
		queue_byte(8'h1f);
		queue_end();
		queue_text("\\");
		queue_end();
		queue_byte(8'hf0);
		queue_byte(8'h90);
		queue_end();

		while (body_q.size() < RANDOM_ITEMS) queue_random_string();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (body_q.size() > 0 || in_ch.valid || expected_q.size() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_n == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
